/* hdl/ir_pulse_width_frame_decoder_defines.svh */
// ----------------------------------------------------------------------------
// IR frame decoder assertion macros
// Shared concurrent assertion forms, clocked on clk, quiet while in reset.
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH
`define IR_PULSE_WIDTH_FRAME_DECODER_DEFINES_SVH

// same-cycle implication
`define IRPWFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IRPWFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/irpwfd_pkg.sv */
// ----------------------------------------------------------------------------
// IR frame decoder package
// Register codes, reset values, shared structs and the window compare.
// ----------------------------------------------------------------------------
package irpwfd_pkg;

    localparam int TicksWidth  = 16;
    localparam int CfgWidth    = 12;
    localparam int CfgIdxWidth = 3;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_HEADER_HIGH_CENTER = 3'd0,
        REG_HEADER_LOW_CENTER  = 3'd1,
        REG_HEADER_TOLERANCE   = 3'd2,
        REG_ONE_HIGH_CENTER    = 3'd3,
        REG_ZERO_HIGH_CENTER   = 3'd4,
        REG_BIT_LOW_CENTER     = 3'd5,
        REG_BIT_TOLERANCE      = 3'd6
    } cfg_index_t;

    localparam logic [11:0] RstHeaderHighCenter = 12'd276;
    localparam logic [11:0] RstHeaderLowCenter  = 12'd580;
    localparam logic [9:0]  RstHeaderTolerance  = 10'd72;
    localparam logic [9:0]  RstOneHighCenter    = 10'd102;
    localparam logic [9:0]  RstZeroHighCenter   = 10'd37;
    localparam logic [9:0]  RstBitLowCenter     = 10'd36;
    localparam logic [7:0]  RstBitTolerance     = 8'd12;

    localparam logic [7:0] MarkOne = 8'h80;

    typedef struct packed {
        logic [11:0] header_high_center;
        logic [11:0] header_low_center;
        logic [9:0]  header_tolerance;
        logic [9:0]  one_high_center;
        logic [9:0]  zero_high_center;
        logic [9:0]  bit_low_center;
        logic [7:0]  bit_tolerance;
    } cfg_regs_t;

    // window hits for one phase, plus its level
    typedef struct packed {
        logic level;
        logic hdr_low;
        logic hdr_high;
        logic bit_low;
        logic is_one;
        logic is_zero;
    } phase_match_t;

    typedef struct packed {
        logic [7:0] address_byte;
        logic [7:0] address_check_byte;
        logic [7:0] command_byte;
        logic [7:0] command_check_byte;
        logic       command_ok;
    } frame_result_t;

    // strict window: center - tol < ticks < center + tol
    function automatic logic in_window(input logic [TicksWidth-1:0] ticks,
                                       input logic [11:0] center,
                                       input logic [9:0]  tol);
        logic [16:0] hi;
        logic        lo_ok;
        logic        hi_ok;
        hi    = 17'(center) + 17'(tol);
        lo_ok = ({2'b00, tol} > center) || (ticks > {4'b0000, center - {2'b00, tol}});
        hi_ok = {1'b0, ticks} < hi;
        return lo_ok && hi_ok;
    endfunction

endpackage

/* hdl/irpwfd_ifs.sv */
// ----------------------------------------------------------------------------
// IR frame decoder channels
// Valid/ready channels for measured phases and decoded frames.
// ----------------------------------------------------------------------------
interface irpwfd_phase_if;
    logic        valid;
    logic        ready;
    logic        phase_level;
    logic [15:0] phase_ticks;

    modport source (output valid, phase_level, phase_ticks, input ready);
    modport sink (input valid, phase_level, phase_ticks, output ready);
endinterface

interface irpwfd_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] address_byte;
    logic [7:0] address_check_byte;
    logic [7:0] command_byte;
    logic [7:0] command_check_byte;
    logic       command_ok;

    modport source (output valid, address_byte, address_check_byte, command_byte,
                    command_check_byte, command_ok, input ready);
    modport sink (input valid, address_byte, address_check_byte, command_byte,
                  command_check_byte, command_ok, output ready);
endinterface

/* hdl/ir_pulse_width_frame_decoder.sv */
// ----------------------------------------------------------------------------
// IR pulse-width frame decoder
// Decodes NEC-style remote frames from a stream of measured line phases.
// ----------------------------------------------------------------------------
// Usage:
//   phase : one item per ended line phase (phase_level, phase_ticks in ticks).
//           Only the low DURATION_BITS bits of phase_ticks are compared.
//   frame : one item per complete 32-bit frame: four bytes in arrival order
//           and command_ok, set when command_byte == ~command_check_byte.
//   cfg   : cfg_we/cfg_index/cfg_wdata write the window centers and
//           tolerances; write only while no phase is in flight.
// Path: the phase item completing the frame passes the input register, then
//   the result register, which raises frame.valid.
// Throughput: one phase item per cycle; the phase path never waits for a
//   result unless a new frame completes while the previous one is unread.
// Stall: a held frame stays put while frame.ready is low; phases that do
//   not complete a frame keep flowing through the input register.
// Reset: all windows return to their default NEC timing, the decoder drops
//   any armed start or frame in progress; no clearing pass is needed.
// ----------------------------------------------------------------------------
module ir_pulse_width_frame_decoder
    import irpwfd_pkg::*;
#(
    parameter int DURATION_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CfgIdxWidth-1:0] cfg_index,
    input  logic [CfgWidth-1:0]    cfg_wdata,
    irpwfd_phase_if.sink           phase,
    irpwfd_frame_if.source         frame
);

    // ticks beyond the measured duration width are ignored
    localparam logic [TicksWidth-1:0] TicksMask = (DURATION_BITS >= TicksWidth) ?
        {TicksWidth{1'b1}} : TicksWidth'((64'd1 << DURATION_BITS) - 64'd1);

    cfg_regs_t             cfg_reg;

    // input register
    logic                  in_valid_reg;
    logic                  in_level_reg;
    logic [TicksWidth-1:0] in_ticks_reg;

    phase_match_t          match;
    frame_result_t         result;
    logic                  item_taken;
    logic                  accept;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_high_center <= RstHeaderHighCenter;
            cfg_reg.header_low_center  <= RstHeaderLowCenter;
            cfg_reg.header_tolerance   <= RstHeaderTolerance;
            cfg_reg.one_high_center    <= RstOneHighCenter;
            cfg_reg.zero_high_center   <= RstZeroHighCenter;
            cfg_reg.bit_low_center     <= RstBitLowCenter;
            cfg_reg.bit_tolerance      <= RstBitTolerance;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_HEADER_HIGH_CENTER: cfg_reg.header_high_center <= cfg_wdata;
                REG_HEADER_LOW_CENTER:  cfg_reg.header_low_center  <= cfg_wdata;
                REG_HEADER_TOLERANCE:   cfg_reg.header_tolerance   <= cfg_wdata[9:0];
                REG_ONE_HIGH_CENTER:    cfg_reg.one_high_center    <= cfg_wdata[9:0];
                REG_ZERO_HIGH_CENTER:   cfg_reg.zero_high_center   <= cfg_wdata[9:0];
                REG_BIT_LOW_CENTER:     cfg_reg.bit_low_center     <= cfg_wdata[9:0];
                REG_BIT_TOLERANCE:      cfg_reg.bit_tolerance      <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // input stage refills as soon as its item moves on
    assign phase.ready = !in_valid_reg || item_taken;
    assign accept      = phase.valid && phase.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (accept)
            in_valid_reg <= 1'b1;
        else if (item_taken)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_level_reg <= phase.phase_level;
            in_ticks_reg <= phase.phase_ticks & TicksMask;
        end
    end

    irpwfd_classify u_classify (
        .level (in_level_reg),
        .ticks (in_ticks_reg),
        .cfg   (cfg_reg),
        .match (match)
    );

    irpwfd_frame u_frame (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .match      (match),
        .item_taken (item_taken),
        .out_valid  (frame.valid),
        .out_ready  (frame.ready),
        .result     (result)
    );

    assign frame.address_byte       = result.address_byte;
    assign frame.address_check_byte = result.address_check_byte;
    assign frame.command_byte       = result.command_byte;
    assign frame.command_check_byte = result.command_check_byte;
    assign frame.command_ok         = result.command_ok;

endmodule

/* hdl/irpwfd_classify.sv */
// ----------------------------------------------------------------------------
// IR frame decoder phase classifier
// Window compares of one registered phase against all configured windows.
// ----------------------------------------------------------------------------
module irpwfd_classify
    import irpwfd_pkg::*;
(
    input  logic                  level,
    input  logic [TicksWidth-1:0] ticks,
    input  cfg_regs_t             cfg,
    output phase_match_t          match
);

    always_comb
    begin
        match.level    = level;
        match.hdr_low  = in_window(ticks, cfg.header_low_center, cfg.header_tolerance);
        match.hdr_high = in_window(ticks, cfg.header_high_center, cfg.header_tolerance);
        match.bit_low  = in_window(ticks, 12'(cfg.bit_low_center), 10'(cfg.bit_tolerance));
        match.is_one   = in_window(ticks, 12'(cfg.one_high_center), 10'(cfg.bit_tolerance));
        match.is_zero  = in_window(ticks, 12'(cfg.zero_high_center), 10'(cfg.bit_tolerance));
    end

endmodule

/* hdl/irpwfd_frame.sv */
// ----------------------------------------------------------------------------
// IR frame decoder frame assembler
// Start detect, LSB-first bit shifting, byte capture and result register.
// ----------------------------------------------------------------------------
module irpwfd_frame
    import irpwfd_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    input  phase_match_t  match,
    output logic          item_taken,
    output logic          out_valid,
    input  logic          out_ready,
    output frame_result_t result
);

    logic          armed_reg, armed_next;
    logic          recv_reg, recv_next;
    logic [4:0]    count_reg, count_next;
    logic [7:0]    shift_reg, shift_next;
    logic [7:0]    held_reg [3];
    logic [7:0]    held_next [3];
    logic          out_valid_reg;
    frame_result_t result_reg;

    logic          produce;
    frame_result_t result_next;
    logic [7:0]    sb_base;
    logic [7:0]    sb_set;
    logic [5:0]    n;

    always_comb
    begin
        armed_next   = armed_reg;
        recv_next    = recv_reg;
        count_next   = count_reg;
        shift_next   = shift_reg;
        held_next    = held_reg;
        produce      = 1'b0;
        sb_base      = (count_reg == 5'd0) ? 8'h00 : shift_reg;
        sb_set       = sb_base | (match.is_one ? MarkOne : 8'h00);
        n            = {1'b0, count_reg} + 6'd1;
        result_next.address_byte       = held_reg[0];
        result_next.address_check_byte = held_reg[1];
        result_next.command_byte       = held_reg[2];
        result_next.command_check_byte = sb_set;
        result_next.command_ok         = (held_reg[2] == ~sb_set);

        if (!match.level)
        begin
            if (match.hdr_low)
            begin
                // header low always re-arms, even mid-frame
                recv_next  = 1'b0;
                armed_next = 1'b1;
                count_next = 5'd0;
            end
            else if (recv_reg && !match.bit_low)
            begin
                armed_next = 1'b0;
                recv_next  = 1'b0;
                count_next = 5'd0;
            end
        end
        else if (armed_reg && match.hdr_high)
        begin
            armed_next = 1'b0;
            recv_next  = 1'b1;
            count_next = 5'd0;
        end
        else if (!recv_reg)
        begin
            armed_next = 1'b0;
            count_next = 5'd0;
        end
        else if (match.is_one || match.is_zero)
        begin
            if (count_reg == 5'd0)
            begin
                held_next[0] = 8'h00;
                held_next[1] = 8'h00;
                held_next[2] = 8'h00;
            end
            case (n)
                6'd8:    held_next[0] = sb_set;
                6'd16:   held_next[1] = sb_set;
                6'd24:   held_next[2] = sb_set;
                6'd32:
                begin
                    produce   = 1'b1;
                    recv_next = 1'b0;
                end
                default: ;
            endcase
            count_next = n[4:0];
            shift_next = sb_set >> 1;
        end
    end

    // a result-bearing item waits only while the result register is full and stalled
    assign item_taken = item_valid && !(produce && out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            recv_reg      <= 1'b0;
            count_reg     <= 5'd0;
            shift_reg     <= 8'h00;
            held_reg[0]   <= 8'h00;
            held_reg[1]   <= 8'h00;
            held_reg[2]   <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_taken)
            begin
                armed_reg <= armed_next;
                recv_reg  <= recv_next;
                count_reg <= count_next;
                shift_reg <= shift_next;
                held_reg  <= held_next;
            end
            if (item_taken && produce)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_taken && produce)
            result_reg <= result_next;
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

/* hdl/irpwfd_checker.sv */
// ----------------------------------------------------------------------------
// IR frame decoder port checker
// Port-level assertions on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ir_pulse_width_frame_decoder_defines.svh"

module irpwfd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       phase_valid,
    input logic       phase_ready,
    input logic       phase_level,
    input logic       frame_valid,
    input logic       frame_ready,
    input logic [7:0] command_byte,
    input logic [7:0] command_check_byte,
    input logic       command_ok
);

    `IRPWFD_ASSERT_NEXT(a_frame_hold, frame_valid && !frame_ready,
        frame_valid && $stable(command_byte) && $stable(command_check_byte),
        "frame item changed while stalled")

    `IRPWFD_ASSERT_NOW(a_cmd_ok, frame_valid,
        command_ok == (command_byte == ~command_check_byte),
        "command_ok disagrees with bytes")

    // a new frame follows the accepted phase that completed it, through the input and result registers
    `IRPWFD_ASSERT_NOW(a_frame_cause, $rose(frame_valid),
        $past(phase_valid && phase_ready, 2),
        "frame appeared without a causing phase")

    // only a high phase can complete a frame
    `IRPWFD_ASSERT_NOW(a_frame_high, $rose(frame_valid),
        $past(phase_level, 2),
        "frame completed by a low phase")

endmodule

bind ir_pulse_width_frame_decoder irpwfd_checker u_irpwfd_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .phase_valid        (phase.valid),
    .phase_ready        (phase.ready),
    .phase_level        (phase.phase_level),
    .frame_valid        (frame.valid),
    .frame_ready        (frame.ready),
    .command_byte       (frame.command_byte),
    .command_check_byte (frame.command_check_byte),
    .command_ok         (frame.command_ok)
);
